// ===== rtl/core/ovau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ovau_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 16;
  localparam int WORK_FRAC       = 30;

  localparam int NUM_IN_FIELDS = 9;
  localparam int IN_TDATA_W    = ((NUM_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_W         = 16;

  localparam int PROD_W   = 2 * COORD_WIDTH;
  localparam int CROSS_W  = 2 * COORD_WIDTH + 1;
  localparam int DOT_W    = 2 * COORD_WIDTH + 2;
  localparam int OPROD_W  = CROSS_W + COORD_WIDTH;
  localparam int ORIENT_W = OPROD_W + 2;
  localparam int NORM_W   = DOT_W;
  localparam int LEN_W    = $clog2(NORM_W + 1) + 1;
  localparam int EXT_W    = NORM_W + WORK_FRAC;
  localparam int S_W      = WORK_FRAC + 1;
  localparam int SUM_W    = 2 * S_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int XY_W     = WORK_FRAC + 5;
  localparam int ACC_W    = WORK_FRAC + 4;
  localparam int ANG_W    = WORK_FRAC + 3;
  localparam int RND_SH   = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int RES_W    = ANG_W + 1 - RND_SH;

  localparam longint PI_W      = 64'd3373259426;
  localparam longint HALF_PI_W = 64'd1686629713;
  localparam longint TWO_PI_W  = 64'd6746518852;
  localparam longint FULL_RES  = (TWO_PI_W + (64'd1 << (RND_SH - 1))) >> RND_SH;

  localparam logic [WORK_FRAC-1:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // travels beside the magnitude through the square root and the rotations
  typedef struct packed {
    logic [S_W-1:0] dot;
    logic           flip;
    logic           degen;
  } ovau_side_t;

endpackage
`default_nettype wire

// ===== rtl/core/ovau_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovau_isqrt (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [ovau_pkg::SUM_W-1:0]      in_sum,
  input  wire ovau_pkg::ovau_side_t            in_side,
  output logic                                 out_valid,
  output logic [ovau_pkg::ROOT_W-1:0]          out_root,
  output ovau_pkg::ovau_side_t                 out_side
);

  localparam int N = ovau_pkg::ROOT_W;

  logic                          vld  [N];
  logic [ovau_pkg::ROOT_W-1:0]   root [N];
  ovau_pkg::ovau_side_t          side [N];
  logic [ovau_pkg::SUM_W-1:0]    rad  [N-1];
  logic [ovau_pkg::REM_W-1:0]    rem  [N-1];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic                        pv;
    logic [ovau_pkg::SUM_W-1:0]  prad;
    logic [ovau_pkg::REM_W-1:0]  prem;
    logic [ovau_pkg::ROOT_W-1:0] proot;
    ovau_pkg::ovau_side_t        pside;
    logic [ovau_pkg::REM_W-1:0]  rem_sh;
    logic [ovau_pkg::REM_W-1:0]  trial;
    logic                        fits;

    if (j == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_sum;
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[j-1];
      assign prad  = rad[j-1];
      assign prem  = rem[j-1];
      assign proot = root[j-1];
      assign pside = side[j-1];
    end

    // bring down the next pair of radicand bits and try root*4+1
    assign rem_sh = {prem[ovau_pkg::REM_W-3:0], prad[ovau_pkg::SUM_W-1-2*j -: 2]};
    assign trial  = {proot, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root[j] <= {proot[ovau_pkg::ROOT_W-2:0], fits};
        side[j] <= pside;
      end
    end

    if (j < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad[j] <= prad;
          rem[j] <= fits ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_root  = root[N-1];
  assign out_side  = side[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/ovau_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovau_cordic (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic [ovau_pkg::ROOT_W-1:0]         in_ymag,
  input  wire ovau_pkg::ovau_side_t                in_side,
  output logic                                     out_valid,
  output logic signed [ovau_pkg::ACC_W-1:0]        out_acc,
  output ovau_pkg::ovau_side_t                     out_side
);

  localparam int N = ovau_pkg::CORDIC_STEPS;
  localparam logic signed [ovau_pkg::ACC_W-1:0] HALF_PI_ACC =
    ovau_pkg::ACC_W'(ovau_pkg::HALF_PI_W);

  logic                               vld  [N];
  logic signed [ovau_pkg::ACC_W-1:0]  acc  [N];
  ovau_pkg::ovau_side_t               side [N];
  logic signed [ovau_pkg::XY_W-1:0]   xr   [N-1];
  logic signed [ovau_pkg::XY_W-1:0]   yr   [N-1];

  logic signed [ovau_pkg::XY_W-1:0] dot_x;
  logic signed [ovau_pkg::XY_W-1:0] mag_x;

  assign dot_x = ovau_pkg::XY_W'($signed(in_side.dot));
  assign mag_x = $signed(ovau_pkg::XY_W'(in_ymag));

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                              pv;
    logic signed [ovau_pkg::XY_W-1:0]  px;
    logic signed [ovau_pkg::XY_W-1:0]  py;
    logic signed [ovau_pkg::ACC_W-1:0] pacc;
    ovau_pkg::ovau_side_t              pside;
    logic signed [ovau_pkg::ACC_W-1:0] tab;
    logic                              up;

    if (i == 0) begin : g_first
      // a negative dot product starts a quarter turn in
      assign pv    = in_valid;
      assign px    = (dot_x < 0) ? mag_x : dot_x;
      assign py    = (dot_x < 0) ? -dot_x : mag_x;
      assign pacc  = (dot_x < 0) ? HALF_PI_ACC : '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[i-1];
      assign px    = xr[i-1];
      assign py    = yr[i-1];
      assign pacc  = acc[i-1];
      assign pside = side[i-1];
    end

    assign tab = $signed(ovau_pkg::ACC_W'(ovau_pkg::ATAN_TAB[i]));
    assign up  = (py > 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i]  <= up ? (pacc + tab) : (pacc - tab);
        side[i] <= pside;
      end
    end

    if (i < N - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          xr[i] <= up ? (px + (py >>> i)) : (px - (py >>> i));
          yr[i] <= up ? (py - (px >>> i)) : (py + (px >>> i));
        end
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_acc   = acc[N-1];
  assign out_side  = side[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/oriented_vector_angle_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Oriented angle between two 3D vectors.
// s_* channel: one item per handshake holds the first vector, the second
// vector and an orientation reference (nine signed 16-bit coordinates).
// m_* channel: the angle atan2(|a x b|, a.b) in radians, 13 fraction bits,
// taken as 2*pi minus that angle when (a x b).ref is negative; m_tuser is
// high (angle 0) when the cross product is zero.
// The chain is 7 arithmetic stages, 31 square-root stages (one root bit
// each), 16 rotation stages and one final clamp-and-reflect stage whose
// result is rounded into the output queue.
// Throughput: one item per cycle while results are taken.
// The pipeline ends in a two-entry output queue; the whole pipeline holds
// only when that queue is full, so input is still taken while a result
// waits. s_tready comes from a register and does not depend on m_tready.
// Reset empties the pipeline and the queue; no items are lost afterward.
module oriented_vector_angle_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, ref_x, ref_y, ref_z
  input  wire logic [ovau_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // angle_rad
  output logic [ovau_pkg::OUT_W-1:0]             m_tdata,
  // status
  output logic                                   m_tuser
);

  localparam int CW = ovau_pkg::COORD_WIDTH;
  localparam logic signed [ovau_pkg::ACC_W-1:0] PI_ACC =
    ovau_pkg::ACC_W'(ovau_pkg::PI_W);
  localparam logic [ovau_pkg::ANG_W-1:0] TWO_PI_ANG =
    ovau_pkg::ANG_W'(ovau_pkg::TWO_PI_W);
  localparam logic [ovau_pkg::RES_W-1:0] FULL_RES =
    ovau_pkg::RES_W'(ovau_pkg::FULL_RES);
  localparam logic [ovau_pkg::ANG_W:0] RND_HALF =
    (ovau_pkg::ANG_W + 1)'(1) << (ovau_pkg::RND_SH - 1);

  logic en;

  // input fields
  logic signed [CW-1:0] ax, ay, az, bx, by, bz, rx, ry, rz;
  assign ax = s_tdata[0*CW +: CW];
  assign ay = s_tdata[1*CW +: CW];
  assign az = s_tdata[2*CW +: CW];
  assign bx = s_tdata[3*CW +: CW];
  assign by = s_tdata[4*CW +: CW];
  assign bz = s_tdata[5*CW +: CW];
  assign rx = s_tdata[6*CW +: CW];
  assign ry = s_tdata[7*CW +: CW];
  assign rz = s_tdata[8*CW +: CW];

  // stage 1: products
  logic v1;
  logic signed [ovau_pkg::PROD_W-1:0] p_ay_bz, p_az_by, p_az_bx, p_ax_bz, p_ax_by, p_ay_bx;
  logic signed [ovau_pkg::PROD_W-1:0] p_ax_bx, p_ay_by, p_az_bz;
  logic signed [CW-1:0] rx1, ry1, rz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ay_bz <= ay * bz;
      p_az_by <= az * by;
      p_az_bx <= az * bx;
      p_ax_bz <= ax * bz;
      p_ax_by <= ax * by;
      p_ay_bx <= ay * bx;
      p_ax_bx <= ax * bx;
      p_ay_by <= ay * by;
      p_az_bz <= az * bz;
      rx1 <= rx;
      ry1 <= ry;
      rz1 <= rz;
    end
  end

  // stage 2: cross and dot products
  logic v2;
  logic signed [ovau_pkg::CROSS_W-1:0] cx, cy, cz;
  logic signed [ovau_pkg::DOT_W-1:0]   dt;
  logic signed [CW-1:0] rx2, ry2, rz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx  <= ovau_pkg::CROSS_W'(p_ay_bz) - ovau_pkg::CROSS_W'(p_az_by);
      cy  <= ovau_pkg::CROSS_W'(p_az_bx) - ovau_pkg::CROSS_W'(p_ax_bz);
      cz  <= ovau_pkg::CROSS_W'(p_ax_by) - ovau_pkg::CROSS_W'(p_ay_bx);
      dt  <= ovau_pkg::DOT_W'(p_ax_bx) + ovau_pkg::DOT_W'(p_ay_by)
           + ovau_pkg::DOT_W'(p_az_bz);
      rx2 <= rx1;
      ry2 <= ry1;
      rz2 <= rz1;
    end
  end

  // stage 3: orientation products, magnitude bits, zero test
  logic v3, degen3;
  logic signed [ovau_pkg::OPROD_W-1:0] o0, o1, o2;
  logic signed [ovau_pkg::NORM_W-1:0]  n0, n1, n2, n3;
  logic [ovau_pkg::NORM_W-1:0]         mag3;
  logic signed [ovau_pkg::NORM_W-1:0]  e0, e1, e2, e3;

  assign e0 = ovau_pkg::NORM_W'(cx);
  assign e1 = ovau_pkg::NORM_W'(cy);
  assign e2 = ovau_pkg::NORM_W'(cz);
  assign e3 = ovau_pkg::NORM_W'(dt);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o0     <= ovau_pkg::OPROD_W'(cx) * ovau_pkg::OPROD_W'(rx2);
      o1     <= ovau_pkg::OPROD_W'(cy) * ovau_pkg::OPROD_W'(ry2);
      o2     <= ovau_pkg::OPROD_W'(cz) * ovau_pkg::OPROD_W'(rz2);
      degen3 <= (cx == 0) && (cy == 0) && (cz == 0);
      // one's complement of negatives: within 2^k exactly when below 2^k
      mag3   <= (e0 ^ {ovau_pkg::NORM_W{e0[ovau_pkg::NORM_W-1]}})
              | (e1 ^ {ovau_pkg::NORM_W{e1[ovau_pkg::NORM_W-1]}})
              | (e2 ^ {ovau_pkg::NORM_W{e2[ovau_pkg::NORM_W-1]}})
              | (e3 ^ {ovau_pkg::NORM_W{e3[ovau_pkg::NORM_W-1]}});
      n0 <= e0;
      n1 <= e1;
      n2 <= e2;
      n3 <= e3;
    end
  end

  // stage 4: orientation sign, leading bit
  logic v4, degen4, flip4;
  logic [ovau_pkg::LEN_W-1:0]         len4, len_c;
  logic signed [ovau_pkg::NORM_W-1:0] m0, m1, m2, m3;
  logic signed [ovau_pkg::ORIENT_W-1:0] osum;

  assign osum = ovau_pkg::ORIENT_W'(o0) + ovau_pkg::ORIENT_W'(o1) + ovau_pkg::ORIENT_W'(o2);

  always_comb begin
    len_c = '0;
    for (int j = 0; j < ovau_pkg::NORM_W; j++) begin
      if (mag3[j]) len_c = ovau_pkg::LEN_W'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flip4  <= osum[ovau_pkg::ORIENT_W-1];
      degen4 <= degen3;
      len4   <= len_c;
      m0 <= n0;
      m1 <= n1;
      m2 <= n2;
      m3 <= n3;
    end
  end

  // stage 5: scale all four so the largest magnitude lands in [2^29, 2^30)
  logic v5, degen5, flip5;
  logic signed [ovau_pkg::S_W-1:0] s0, s1, s2, s3;
  logic                            go_right;
  logic [ovau_pkg::LEN_W-1:0]      rsh, lsh;

  assign go_right = (len4 > ovau_pkg::LEN_W'(ovau_pkg::WORK_FRAC));
  assign rsh      = len4 - ovau_pkg::LEN_W'(ovau_pkg::WORK_FRAC);
  assign lsh      = ovau_pkg::LEN_W'(ovau_pkg::WORK_FRAC) - len4;

  function automatic logic signed [ovau_pkg::S_W-1:0] scale(
    input logic signed [ovau_pkg::NORM_W-1:0] v,
    input logic                               right,
    input logic [ovau_pkg::LEN_W-1:0]         rs,
    input logic [ovau_pkg::LEN_W-1:0]         ls
  );
    logic signed [ovau_pkg::EXT_W-1:0] ext;
    logic signed [ovau_pkg::EXT_W-1:0] sh;
    ext = ovau_pkg::EXT_W'(v);
    sh  = right ? (ext >>> rs) : (ext <<< ls);
    return sh[ovau_pkg::S_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= scale(m0, go_right, rsh, lsh);
      s1 <= scale(m1, go_right, rsh, lsh);
      s2 <= scale(m2, go_right, rsh, lsh);
      s3 <= scale(m3, go_right, rsh, lsh);
      degen5 <= degen4;
      flip5  <= flip4;
    end
  end

  // stage 6: squares
  logic v6;
  logic signed [ovau_pkg::SUM_W-1:0] q0, q1, q2;
  logic [ovau_pkg::SUM_W-1:0] sq0, sq1, sq2;
  ovau_pkg::ovau_side_t side6, side7, side_r, side_c;

  assign q0 = ovau_pkg::SUM_W'(s0) * ovau_pkg::SUM_W'(s0);
  assign q1 = ovau_pkg::SUM_W'(s1) * ovau_pkg::SUM_W'(s1);
  assign q2 = ovau_pkg::SUM_W'(s2) * ovau_pkg::SUM_W'(s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq0 <= $unsigned(q0);
      sq1 <= $unsigned(q1);
      sq2 <= $unsigned(q2);
      side6.dot   <= s3;
      side6.flip  <= flip5;
      side6.degen <= degen5;
    end
  end

  // stage 7: sum of squares
  logic v7;
  logic [ovau_pkg::SUM_W-1:0] sum7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum7  <= sq0 + sq1 + sq2;
      side7 <= side6;
    end
  end

  logic                        vr;
  logic [ovau_pkg::ROOT_W-1:0] root_r;

  ovau_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_sum    (sum7),
    .in_side   (side7),
    .out_valid (vr),
    .out_root  (root_r),
    .out_side  (side_r)
  );

  logic                              vc;
  logic signed [ovau_pkg::ACC_W-1:0] acc_c;

  ovau_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vr),
    .in_ymag   (root_r),
    .in_side   (side_r),
    .out_valid (vc),
    .out_acc   (acc_c),
    .out_side  (side_c)
  );

  // stage 8: clamp to [0, pi], reflect
  logic v8, degen8;
  logic [ovau_pkg::ANG_W-1:0] ang8, clamp_c;

  always_comb begin
    if (acc_c < 0) begin
      clamp_c = '0;
    end else if (acc_c > PI_ACC) begin
      clamp_c = ovau_pkg::ANG_W'(PI_ACC);
    end else begin
      clamp_c = ovau_pkg::ANG_W'(acc_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang8   <= side_c.flip ? (TWO_PI_ANG - clamp_c) : clamp_c;
      degen8 <= side_c.degen;
    end
  end

  // rounding into the output queue
  logic [ovau_pkg::ANG_W:0]   rnd_sum;
  logic [ovau_pkg::RES_W-1:0] res;
  logic [ovau_pkg::OUT_W-1:0] angle_out;

  assign rnd_sum   = ({1'b0, ang8} + RND_HALF);
  assign res       = rnd_sum[ovau_pkg::ANG_W -: ovau_pkg::RES_W];
  // a full turn after rounding wraps to zero
  assign angle_out = (degen8 || res >= FULL_RES) ? '0 : res[ovau_pkg::OUT_W-1:0];

  logic [ovau_pkg::OUT_W:0] fifo_mem [2];
  logic                     wr_ptr, rd_ptr;
  logic [1:0]               fifo_count;
  logic                     push, pop;

  assign en       = (fifo_count != 2'd2);
  assign s_tready = en;
  assign push     = en && v8;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fifo_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fifo_count <= fifo_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= {degen8, angle_out};
    end
  end

  assign m_tvalid = (fifo_count != 2'd0);
  assign m_tdata  = fifo_mem[rd_ptr][ovau_pkg::OUT_W-1:0];
  assign m_tuser  = fifo_mem[rd_ptr][ovau_pkg::OUT_W];

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fifo_count != 2'd3)
    else $error("output queue count out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> fifo_count == 2'd2)
    else $error("input held while queue has room");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {1'b0, m_tdata} < FULL_RES)
    else $error("angle at or above a full turn");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    fifo_count == 2'd2 && !m_tready |=> fifo_count == 2'd2)
    else $error("queue changed while full and stalled");

endmodule
`default_nettype wire

// ===== tb/oriented_vector_angle_checker.sv =====
`timescale 1ns / 1ps
module oriented_vector_angle_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  input  wire logic                               s_tready,
  input  wire logic [ovau_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire logic                               m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic [ovau_pkg::OUT_W-1:0]         m_tdata,
  input  wire logic                               m_tuser,
  output int                                      errors,
  output int                                      pending,
  output int                                      degen_seen,
  output int                                      reflex_seen
);

  typedef struct packed {
    logic [15:0] angle;
    logic        degen;
  } angle_res_t;

  angle_res_t angle_q[$];

  localparam longint ATAN_W [16] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767
  };

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angle_res_t predict_angle(logic [ovau_pkg::IN_TDATA_W-1:0] d);
    logic signed [127:0] c [4];
    logic signed [127:0] orient;
    longint s [4];
    longint x, y, t, acc;
    longint unsigned sum, res, full;
    logic signed [15:0] co [9];
    bit fits;
    angle_res_t r;
    for (int k = 0; k < 9; k++) co[k] = d[16*k +: 16];
    c[0] = 128'(co[1]) * co[5] - 128'(co[2]) * co[4];
    c[1] = 128'(co[2]) * co[3] - 128'(co[0]) * co[5];
    c[2] = 128'(co[0]) * co[4] - 128'(co[1]) * co[3];
    c[3] = 128'(co[0]) * co[3] + 128'(co[1]) * co[4] + 128'(co[2]) * co[5];
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      r.angle = '0;
      r.degen = 1'b1;
      return r;
    end
    orient = c[0] * co[6] + c[1] * co[7] + c[2] * co[8];
    // normalize so the largest magnitude falls in [2^29, 2^30)
    forever begin
      fits = 1;
      for (int k = 0; k < 4; k++)
        if (c[k] >= (128'sd1 <<< 30) || c[k] < -(128'sd1 <<< 30)) fits = 0;
      if (fits) break;
      for (int k = 0; k < 4; k++) c[k] = c[k] >>> 1;
    end
    forever begin
      fits = 1;
      for (int k = 0; k < 4; k++)
        if (c[k] >= (128'sd1 <<< 29) || c[k] < -(128'sd1 <<< 29)) fits = 0;
      if (!fits) break;
      for (int k = 0; k < 4; k++) c[k] = c[k] <<< 1;
    end
    for (int k = 0; k < 4; k++) s[k] = c[k][63:0];
    sum = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
    if (s[3] < 0) begin
      x = root_floor(sum);
      y = -s[3];
      acc = ovau_pkg::HALF_PI_W;
    end else begin
      x = s[3];
      y = root_floor(sum);
      acc = 0;
    end
    for (int i = 0; i < ovau_pkg::CORDIC_STEPS; i++) begin
      if (y > 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        acc += ATAN_W[i];
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        acc -= ATAN_W[i];
      end
      x = t;
    end
    if (acc < 0) acc = 0;
    if (acc > ovau_pkg::PI_W) acc = ovau_pkg::PI_W;
    if (orient < 0) acc = ovau_pkg::TWO_PI_W - acc;
    res = (acc + (64'd1 << (ovau_pkg::RND_SH - 1))) >> ovau_pkg::RND_SH;
    full = (ovau_pkg::TWO_PI_W + (64'd1 << (ovau_pkg::RND_SH - 1))) >> ovau_pkg::RND_SH;
    if (res >= full) res = 0;
    r.angle = res[15:0];
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    degen_seen = 0;
    reflex_seen = 0;
  end

  always @(posedge clk) begin
    angle_res_t w;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        w = predict_angle(s_tdata);
        if (w.degen) degen_seen++;
        if (w.angle > 16'd25736) reflex_seen++;
        angle_q.push_back(w);
      end
      if (m_tvalid && m_tready) begin
        if (angle_q.size() == 0) begin
          report_mismatch("unexpected item", m_tdata, -1);
        end else begin
          w = angle_q.pop_front();
          if (m_tdata !== w.angle) report_mismatch("angle_rad", m_tdata, w.angle);
          if (m_tuser !== w.degen) report_mismatch("status", m_tuser, w.degen);
        end
      end
      pending = angle_q.size();
    end
  end
endmodule

// ===== tb/oriented_vector_angle_unit_tb.sv =====
`timescale 1ns / 1ps
module oriented_vector_angle_unit_tb;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [ovau_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [ovau_pkg::OUT_W-1:0] m_tdata;
  logic m_tuser;
  int errors, pending, degen_seen, reflex_seen;
  int src_idle = 0, snk_idle = 0;
  bit hold_sink = 0;
  int quiet = 0;
  int sent = 0;

  localparam int QUIET_LIMIT = 20000;

  always #1 clk = ~clk;

  oriented_vector_angle_unit dut (.*);

  oriented_vector_angle_checker chk (.*);

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 6)) - 3);
      3: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ovau_pkg::IN_TDATA_W-1:0] pack_vec(
      logic [15:0] ax, ay, az, bx, by, bz, rx, ry, rz);
    return {rz, ry, rx, bz, by, bx, az, ay, ax};
  endfunction

  // drop valid only while idling, so each step sees one assignment
  task automatic send(logic [ovau_pkg::IN_TDATA_W-1:0] d);
    while ($urandom_range(1, 100) <= src_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] v [9];
    int m;
    for (int k = 0; k < 9; k++) v[k] = pick_coord();
    m = $urandom_range(0, 9);
    // scaled copy or negation of the first vector (parallel cases), or a zero reference
    if (m == 0) begin
      v[3] = v[0] <<< 1; v[4] = v[1] <<< 1; v[5] = v[2] <<< 1;
    end else if (m == 1) begin
      v[3] = -v[0]; v[4] = -v[1]; v[5] = -v[2];
    end else if (m == 2) begin
      v[6] = 0; v[7] = 0; v[8] = 0;
    end
    send(pack_vec(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]));
  endtask

  // sink side
  initial begin
    @(negedge clk);
    forever begin
      if (hold_sink) m_tready <= 0;
      else m_tready <= ($urandom_range(1, 100) > snk_idle);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed
    send(pack_vec(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(pack_vec(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send(pack_vec(1, 0, 0, 0, 1, 0, 0, 0, -1));
    send(pack_vec(1, 0, 0, 0, 1, 0, 1, 0, 0));
    send(pack_vec(1, 0, 0, 2, 0, 0, 0, 0, 1));
    send(pack_vec(1, 0, 0, -3, 0, 0, 0, 0, 1));
    send(pack_vec(1, 0, 0, -1000, 1, 0, 0, 0, 1));
    send(pack_vec(1, 0, 0, -1000, 1, 0, 0, 0, -1));
    send(pack_vec(1000, 1, 0, 1000, 0, 0, 0, 0, 1));
    send(pack_vec(1000, 1, 0, 1000, 0, 0, 0, 0, -1));
    send(pack_vec(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                  16'h8000, 16'h8000, 16'h8000));
    send(pack_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h7fff, 16'h7fff, 16'h7fff));
    send(pack_vec(16'hffff, 16'hffff, 16'hffff, 1, 1, 1, 16'hffff, 0, 0));
    send(pack_vec(0, 0, 0, 5, 6, 7, 1, 1, 1));
    send(pack_vec(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'hffff));

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 25 : (ph == 1) ? 46 : 0;
      snk_idle = (ph == 0) ? 46 : (ph == 1) ? 25 : 0;
      for (int n = 0; n < 560; n++) begin
        if (ph == 2 && n == 100) begin
          // long receiver stall while items keep coming
          fork
            begin
              hold_sink = 1;
              repeat (300) @(negedge clk);
              hold_sink = 0;
            end
          join_none
        end
        if (ph != 2 && $urandom_range(0, 9) == 0) begin
          s_tvalid <= 0;
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end
        send_random();
      end
    end
    s_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d items: %0d degenerate, %0d reflex angles.",
             sent, degen_seen, reflex_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
